[sv/mrpe_pkg.sv]
// shared types, constants and helpers of the relocation patch engine
package mrpe_pkg;

    localparam int FRAG_SLOTS = 240;
    localparam int SLOT_AW = $clog2(FRAG_SLOTS);
    localparam logic [7:0] FRAG_SLOTS_W = 8'(FRAG_SLOTS);
    localparam int UPPER_REGS = 32;

    localparam logic [31:0] ADDR_LOW = 32'h8100_0000;
    localparam logic [31:0] ADDR_HIGH = 32'h9000_0000;
    localparam logic [7:0] SLOT_BIAS = 8'h10;
    localparam logic [31:0] HI_ROUND = 32'h0000_8000;

    localparam logic [6:0] RT_WORD32 = 7'd2;
    localparam logic [6:0] RT_JUMP26 = 7'd4;
    localparam logic [6:0] RT_HI16 = 7'd5;
    localparam logic [6:0] RT_LO16 = 7'd6;

    localparam logic ACT_MAP = 1'b0;
    localparam logic ACT_RELOC = 1'b1;

    typedef struct packed {
        logic [6:0]  rtype;
        logic [23:0] offset;
        logic [31:0] word;
        logic [31:0] addr;
        logic [23:0] up_offset;
        logic [31:0] up_word;
        logic        mapped;
    } mrpe_item_t;

    typedef struct packed {
        logic [23:0] offset;
        logic [31:0] word;
    } mrpe_result_t;

    function automatic logic mrpe_in_window(input logic [31:0] a);
        return (a >= ADDR_LOW) && (a < ADDR_HIGH);
    endfunction

endpackage

[sv/mrpe_ram.sv]
// generic single write port ram with registered read
module mrpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[sv/mrpe_patch.sv]
// second stage: address translation and patched word assembly
module mrpe_patch (
    input  mrpe_pkg::mrpe_item_t   item,
    input  logic [31:0]            base,
    output mrpe_pkg::mrpe_result_t res0,
    output mrpe_pkg::mrpe_result_t res1,
    output logic                   two
);
    import mrpe_pkg::*;

    logic        hit;
    logic [31:0] t;
    logic [31:0] t_round;

    always_comb
    begin
        hit = item.mapped && (base != 32'h0);
        t = hit ? (base + {12'h000, item.addr[19:0]}) : item.addr;
        t_round = t + HI_ROUND;
        two = 1'b0;
        res0.offset = item.offset;
        res0.word = t;
        res1.offset = item.offset;
        res1.word = {item.word[31:16], t[15:0]};
        case (item.rtype)
            RT_JUMP26:
            begin
                res0.word = {item.word[31:26], t[27:2]};
            end
            RT_LO16:
            begin
                two = 1'b1;
                res0.offset = item.up_offset;
                res0.word = {item.up_word[31:16], t_round[31:16]};
            end
            default:
            begin
                res0.word = t;
            end
        endcase
    end

endmodule

[sv/mips_reloc_patch_engine.sv]
// top level of the mips relocation patch engine
// Two-stage engine: a transaction is registered together with the registered read of the
// fragment base ram, then the translated patch words go to an output register backed by
// one extra slot for the second word of a lo16 relocation. Word32 and jump26 relocations,
// map writes and hi16 records are taken one per cycle while the output is not stalled; a
// lo16 relocation yields two results, and its second holds back a following result item. The
// base table reads as zero after reset through per-slot valid flops; no clearing pass is needed.
module mips_reloc_patch_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  slot,
    input  logic [31:0] slot_base,
    input  logic [31:0] reloc_entry,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] patch_offset,
    output logic [31:0] patch_word,
    output logic        last
);
    import mrpe_pkg::*;

    logic                  in_acc;
    logic [6:0]            rtype;
    logic                  produces;
    logic                  map_we;
    logic [4:0]            up_rd_idx;
    logic [4:0]            up_wr_idx;
    logic [31:0]           xaddr;
    logic [7:0]            idx8;
    logic                  idx_ok;
    mrpe_item_t            item_next;
    logic [31:0]           ram_rdata;
    logic [31:0]           base;
    mrpe_result_t          res0;
    mrpe_result_t          res1;
    logic                  two;
    logic                  load_out;
    logic                  s1_adv;

    logic [FRAG_SLOTS-1:0] slot_vld_reg;
    logic [23:0]           up_off_reg [UPPER_REGS];
    logic [31:0]           up_word_reg [UPPER_REGS];
    logic                  s1_valid_reg;
    mrpe_item_t            s1_item_reg;
    logic                  out_valid_reg;
    mrpe_result_t          out_res_reg;
    logic                  out_last_reg;
    logic                  p_valid_reg;
    mrpe_result_t          p_res_reg;

    assign in_acc = in_valid && in_ready;
    assign rtype = reloc_entry[30:24];
    assign produces = (action == ACT_RELOC)
        && ((rtype == RT_WORD32) || (rtype == RT_JUMP26) || (rtype == RT_LO16));
    assign map_we = in_acc && (action == ACT_MAP) && (slot < FRAG_SLOTS_W);
    assign up_rd_idx = data_word[25:21];
    assign up_wr_idx = data_word[20:16];

    always_comb
    begin
        case (rtype)
            RT_JUMP26:
            begin
                xaddr = {4'h8, data_word[25:0], 2'b00};
            end
            RT_LO16:
            begin
                xaddr = {up_word_reg[up_rd_idx][15:0], 16'h0000}
                    + {{16{data_word[15]}}, data_word[15:0]};
            end
            default:
            begin
                xaddr = data_word;
            end
        endcase
        idx8 = xaddr[27:20] - SLOT_BIAS;
        idx_ok = mrpe_in_window(xaddr) && (idx8 < FRAG_SLOTS_W);
        item_next.rtype = rtype;
        item_next.offset = reloc_entry[23:0];
        item_next.word = data_word;
        item_next.addr = xaddr;
        item_next.up_offset = up_off_reg[up_rd_idx];
        item_next.up_word = up_word_reg[up_rd_idx];
        item_next.mapped = idx_ok && slot_vld_reg[idx8[SLOT_AW-1:0]];
    end

    mrpe_ram #(
        .WIDTH(32),
        .DEPTH(FRAG_SLOTS)
    ) u_base_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (slot[SLOT_AW-1:0]),
        .wdata (slot_base),
        .re    (in_acc && produces),
        .raddr (idx8[SLOT_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign base = s1_item_reg.mapped ? ram_rdata : 32'h0;

    mrpe_patch u_patch (
        .item (s1_item_reg),
        .base (base),
        .res0 (res0),
        .res1 (res1),
        .two  (two)
    );

    assign load_out = !out_valid_reg || out_ready;
    assign s1_adv = s1_valid_reg && !p_valid_reg && load_out;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (map_we)
        begin
            slot_vld_reg[slot[SLOT_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (action == ACT_RELOC) && (rtype == RT_HI16))
        begin
            up_off_reg[up_wr_idx] <= reloc_entry[23:0];
            up_word_reg[up_wr_idx] <= data_word;
        end
        if (in_acc)
        begin
            s1_item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_res_reg <= '0;
            p_res_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= produces;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                if (p_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_res_reg <= p_res_reg;
                    out_last_reg <= 1'b1;
                    p_valid_reg <= 1'b0;
                end
                else if (s1_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_res_reg <= res0;
                    out_last_reg <= !two;
                    p_valid_reg <= two;
                    p_res_reg <= res1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign patch_offset = out_res_reg.offset;
    assign patch_word = out_res_reg.word;
    assign last = out_last_reg;

`ifndef NO_ASSERTIONS
    a_pending_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("second result pending without a first result shown");

    a_pair_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (out_valid && last))
        else $error("first result of a pair not followed by its last result");

    a_no_result_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (action == ACT_MAP)) |=> !s1_valid_reg)
        else $error("map write entered the result stage");
`endif

endmodule

[test/mips_reloc_patch_engine_test.sv]
// self-checking testbench of the mips relocation patch engine
module mips_reloc_patch_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrpe_pkg::*;

    class patch_tracker;
        typedef struct packed {
            bit [23:0] offset;
            bit [31:0] word;
            bit        last;
        } patch_t;

        bit [31:0] base_table[FRAG_SLOTS];
        bit [23:0] upper_offset[UPPER_REGS];
        bit [31:0] upper_value[UPPER_REGS];
        bit        upper_seen[UPPER_REGS];
        patch_t    pending_patches[$];
        int        errors;

        function bit [31:0] map_addr(bit [31:0] a);
            int idx;
            if (a < ADDR_LOW || a >= ADDR_HIGH)
                return a;
            idx = int'(a[27:20]) - int'(SLOT_BIAS);
            if (idx >= FRAG_SLOTS)
                return a;
            if (base_table[idx] == 32'h0)
                return a;
            return base_table[idx] + {12'h000, a[19:0]};
        endfunction

        function void add_patch(bit [23:0] off, bit [31:0] word, bit last);
            patch_t p;
            p.offset = off;
            p.word = word;
            p.last = last;
            pending_patches.push_back(p);
        endfunction

        // accepted input transaction: update state and queue the patches it causes
        function void apply_item(bit act, bit [7:0] sl, bit [31:0] base, bit [31:0] ent,
                                 bit [31:0] w);
            bit [6:0]  kind;
            bit [23:0] off;
            bit [4:0]  r;
            bit [31:0] t;
            bit [31:0] lo;
            bit [31:0] hi_sum;
            if (act == ACT_MAP)
            begin
                if (sl < FRAG_SLOTS)
                    base_table[sl] = base;
                return;
            end
            kind = ent[30:24];
            off = ent[23:0];
            case (kind)
                RT_WORD32: add_patch(off, map_addr(w), 1'b1);
                RT_JUMP26:
                begin
                    t = map_addr({4'h8, w[25:0], 2'b00});
                    add_patch(off, {w[31:26], t[27:2]}, 1'b1);
                end
                RT_HI16:
                begin
                    r = w[20:16];
                    upper_offset[r] = off;
                    upper_value[r] = w;
                    upper_seen[r] = 1'b1;
                end
                RT_LO16:
                begin
                    r = w[25:21];
                    lo = {{16{w[15]}}, w[15:0]};
                    t = map_addr({upper_value[r][15:0], 16'h0000} + lo);
                    hi_sum = t + HI_ROUND;
                    add_patch(upper_offset[r], {upper_value[r][31:16], hi_sum[31:16]},
                              1'b0);
                    add_patch(off, {w[31:16], t[15:0]}, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // accepted output transaction: compare with the oldest queued patch
        function void check_patch(bit [23:0] off, bit [31:0] word, bit last);
            patch_t p;
            if (pending_patches.size() == 0)
            begin
                report($sformatf("unexpected patch: off %06h word %08h last %0d",
                                 off, word, last));
                return;
            end
            p = pending_patches.pop_front();
            if (p.offset != off || p.word != word || p.last != last)
                report($sformatf({"patch mismatch: expected off %06h word %08h last %0d,",
                                  " got off %06h word %08h last %0d"},
                                 p.offset, p.word, p.last, off, word, last));
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_TARGET = 1900;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  slot;
    logic [31:0] slot_base;
    logic [31:0] reloc_entry;
    logic [31:0] data_word;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] patch_offset;
    logic [31:0] patch_word;
    logic        last;

    patch_tracker tracker = new();
    bit calm;
    int items_sent;
    int idle_cycles;
    int stall_left;

    mips_reloc_patch_engine u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .slot(slot),
        .slot_base(slot_base),
        .reloc_entry(reloc_entry),
        .data_word(data_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .patch_offset(patch_offset),
        .patch_word(patch_word),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [31:0] make_entry(bit [6:0] kind);
        bit [31:0] e;
        e = $urandom;
        e[30:24] = kind;
        return e;
    endfunction

    function automatic bit [31:0] rand_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return {4'h8, 8'($urandom_range(16, 255)), 20'($urandom)};
        if (r < 9)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h80ff_ffff;
            1: return ADDR_LOW;
            2: return 32'h8fff_ffff;
            default: return ADDR_HIGH;
        endcase
    endfunction

    function automatic bit [31:0] rand_base();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom;
        if (r < 17)
            return 32'h0;
        return {12'hfff, 20'($urandom)};
    endfunction

    task automatic send_item(input bit act, input bit [7:0] sl, input bit [31:0] base,
                             input bit [31:0] ent, input bit [31:0] w);
        int gap;
        bit [6:0] kind;
        kind = ent[30:24];
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        slot <= sl;
        slot_base <= base;
        reloc_entry <= ent;
        data_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.apply_item(act, sl, base, ent, w);
        if (act == ACT_MAP ? sl < FRAG_SLOTS :
            (kind == RT_WORD32 || kind == RT_JUMP26 || kind == RT_HI16 || kind == RT_LO16))
            items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_reloc(input bit [6:0] kind, input bit [31:0] w);
        send_item(ACT_RELOC, 8'($urandom), $urandom, make_entry(kind), w);
    endtask

    task automatic send_map(input bit [7:0] sl, input bit [31:0] base);
        send_item(ACT_MAP, sl, base, $urandom, $urandom);
    endtask

    // lui/addiu style pair on one register, sometimes with more low halves following
    task automatic send_hi_lo_run();
        bit [4:0]  r;
        bit [31:0] a;
        bit [31:0] hi_part;
        bit [31:0] w;
        int n;
        r = 5'($urandom);
        a = rand_addr();
        hi_part = a - {{16{a[15]}}, a[15:0]};
        w = $urandom;
        w[20:16] = r;
        w[15:0] = hi_part[31:16];
        send_reloc(RT_HI16, w);
        if ($urandom_range(0, 4) == 0)
            send_reloc(RT_WORD32, rand_addr());
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            w = $urandom;
            w[25:21] = r;
            if (n == 1 || $urandom_range(0, 1) == 0)
                w[15:0] = a[15:0];
            send_reloc(RT_LO16, w);
        end
    endtask

    task automatic send_noise();
        bit [6:0]  kind;
        bit [31:0] w;
        case ($urandom_range(0, 3))
            0:
            begin
                kind = 7'($urandom);
                while (kind == RT_WORD32 || kind == RT_JUMP26 || kind == RT_HI16 ||
                       kind == RT_LO16)
                    kind = 7'($urandom);
                send_reloc(kind, $urandom);
            end
            1: send_map(8'($urandom_range(FRAG_SLOTS, 255)), $urandom);
            2: send_reloc(RT_HI16, $urandom);
            default:
            begin
                w = $urandom;
                while (!tracker.upper_seen[w[25:21]])
                    w[25:21] = 5'($urandom);
                send_reloc(RT_LO16, w);
            end
        endcase
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_patch(patch_offset, patch_word, last);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("mips_reloc_patch_engine regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_MAP;
        slot = 8'h00;
        slot_base = 32'h0;
        reloc_entry = 32'h0;
        data_word = 32'h0;
        out_ready = 1'b0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b0, RT_WORD32, 24'h000000}, 32'h8100_0010);
        send_map(8'd0, 32'h8040_0000);
        send_map(8'd239, 32'hffff_f000);
        send_map(8'd238, 32'hffff_0000);
        send_map(8'd240, 32'h1234_5678);
        send_map(8'd255, 32'hdead_beef);
        send_item(ACT_RELOC, 8'hff, 32'hffff_ffff, {1'b1, RT_WORD32, 24'hffffff}, ADDR_LOW);
        send_reloc(RT_WORD32, 32'h8fff_ffff);
        send_reloc(RT_WORD32, 32'h80ff_ffff);
        send_reloc(RT_WORD32, ADDR_HIGH);
        send_reloc(RT_WORD32, 32'hffff_ffff);
        send_reloc(RT_JUMP26, 32'hfc40_0004);
        send_reloc(RT_JUMP26, 32'h03ff_ffff);
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b0, RT_HI16, 24'h000100}, 32'h3c1f_8100);
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b0, RT_LO16, 24'h000104}, 32'h27ff_0010);
        send_reloc(RT_LO16, 32'h27ff_8000);
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b1, RT_HI16, 24'hfffffc}, 32'h3c00_8fff);
        send_reloc(RT_LO16, 32'h0000_7ff0);
        send_reloc(RT_HI16, 32'h3c01_8fe1);
        send_reloc(RT_LO16, 32'h2420_8000);
        send_map(8'd5, 32'h0);
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b0, 7'd0, 24'h000000}, 32'h8100_0000);
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b1, 7'd3, 24'h000010}, 32'h8100_0000);
        send_item(ACT_RELOC, 8'h00, 32'h0, {1'b1, 7'd127, 24'hffffff}, 32'h8100_0000);

        // populate up to half of the table first
        for (i = 0; i < 120; i++)
            send_map(8'($urandom_range(0, FRAG_SLOTS - 1)), rand_base());

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 59) == 0)
                calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_map(8'($urandom_range(0, FRAG_SLOTS - 1)), rand_base());
            else if (pick < 28)
                send_reloc(RT_WORD32, rand_addr());
            else if (pick < 43)
                send_reloc(RT_JUMP26, $urandom);
            else if (pick < 90)
                send_hi_lo_run();
            else
                send_noise();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        calm = 1'b0;
        while (tracker.pending_patches.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_patches.size() == 0)
            $display("mips_reloc_patch_engine regression: pass");
        else
            $display("mips_reloc_patch_engine regression: fail");
        $finish;
    end
endmodule
